/* rtl/core/text_telemetry_line_parser_assert.svh */
// Assertion macros shared by the line parser RTL.
// Simulation builds get concurrent assertions; synthesis builds get nothing.
`ifndef TEXT_TELEMETRY_LINE_PARSER_ASSERT_SVH
`define TEXT_TELEMETRY_LINE_PARSER_ASSERT_SVH

`ifndef SYNTHESIS

// Property that must hold at every clock edge outside reset.
`define TTLP_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked in the same cycle.
`define TTLP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the next cycle.
`define TTLP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define TTLP_ASSERT(label, clk, rst_n, prop, msg)
`define TTLP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define TTLP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

/* rtl/core/ttlp_pkg.sv */
// Package of the telemetry line parser: character codes, quantity codes,
// scaling constants and the structs passed between the parser and the scaler.
// No dependencies.
package ttlp_pkg;

  localparam int unsigned VALUE_BITS_DEF = 24;
  localparam int unsigned KEY_CHARS_DEF  = 3;

  // Result field widths.
  localparam int unsigned QTY_W   = 3;
  localparam int unsigned MAG_W   = 24;
  localparam int unsigned WHOLE_W = 15;
  localparam int unsigned HUND_W  = 7;
  localparam int unsigned OUT_W   = QTY_W + MAG_W + 1 + WHOLE_W + HUND_W;
  localparam int unsigned OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

  // Exact division by 1000 of any 32-bit value: (x * RECIP_1000) >> RECIP_SHIFT.
  localparam int unsigned DIV_W       = 32;
  localparam int unsigned RECIP_W     = 29;
  localparam logic [RECIP_W-1:0] RECIP_1000 = 29'd274877907;
  localparam int unsigned RECIP_SHIFT = 38;
  localparam int unsigned PROD_W      = DIV_W + RECIP_W;
  // The remainder is below 1000, so ten low bits carry it exactly.
  localparam int unsigned REM_W       = 10;
  localparam logic [REM_W-1:0] THOUSAND = 10'd1000;
  // Exact division by 10 for values below 1029: (r * 205) >> 11.
  localparam int unsigned TEN_MUL_W   = 18;
  localparam logic [TEN_MUL_W-1:0] RECIP_10 = 18'd205;
  localparam int unsigned TEN_SHIFT   = 11;

  // Characters.
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_I     = 8'h49;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_V     = 8'h56;

  typedef enum logic [QTY_W-1:0] {
    QTY_BATT_V   = 3'd0,
    QTY_PANEL_V  = 3'd1,
    QTY_PANEL_P  = 3'd2,
    QTY_CURRENT  = 3'd3,
    QTY_CHARGE_S = 3'd4
  } quantity_e;

  // Line result handed from the parser to the scaler.
  typedef struct packed {
    logic      valid;
    quantity_e qty;
    logic      neg;
  } line_res_t;

  // Payload of the first scaler stage.
  typedef struct packed {
    quantity_e          qty;
    logic               neg;
    logic [MAG_W-1:0]   mag;
    logic [WHOLE_W-1:0] whole;
    logic [REM_W-1:0]   x_low;
  } quot_stg_t;

  // Payload of the second scaler stage.
  typedef struct packed {
    quantity_e          qty;
    logic               neg;
    logic [MAG_W-1:0]   mag;
    logic [WHOLE_W-1:0] whole;
    logic [REM_W-1:0]   rem;
  } rem_stg_t;

endpackage

/* rtl/core/ttlp_parser.sv */
// Per-line parser state: gathers the key, reads the value like atol and
// reports a recognized line at its newline. Depends on ttlp_pkg.
`include "text_telemetry_line_parser_assert.svh"

module ttlp_parser #(
  parameter int unsigned VALUE_BITS = ttlp_pkg::VALUE_BITS_DEF,
  parameter int unsigned KEY_CHARS  = ttlp_pkg::KEY_CHARS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  byte_en_i,
  input  logic [7:0]            byte_i,
  output ttlp_pkg::line_res_t   res_o,
  output logic [VALUE_BITS-1:0] mag_o
);
  import ttlp_pkg::*;

  localparam int unsigned KLW = $clog2(KEY_CHARS + 2);
  localparam logic [KLW-1:0] KEY_LEN_MAX  = KLW'(KEY_CHARS);
  localparam logic [KLW-1:0] KEY_LEN_LONG = KLW'(KEY_CHARS + 1);
  localparam int unsigned PW = VALUE_BITS + 4;

  logic [7:0]            key_chars_q [KEY_CHARS];
  logic [7:0]            key_chars_d [KEY_CHARS];
  logic [KLW-1:0]        key_len_q, key_len_d;
  logic                  in_value_q, in_value_d;
  logic                  started_q, started_d;
  logic                  done_q, done_d;
  logic                  minus_q, minus_d;
  logic [VALUE_BITS-1:0] acc_q, acc_d;

  logic          is_digit, is_blank, is_sign, is_nl;
  logic [PW-1:0] acc_x10;
  logic          key_ok;
  quantity_e     key_qty;

  assign is_nl    = (byte_i == CH_NL);
  assign is_digit = (byte_i >= CH_0) && (byte_i <= CH_9);
  assign is_blank = (byte_i == CH_SP) || (byte_i == CH_CR) ||
                    (byte_i == CH_VT) || (byte_i == CH_FF);
  assign is_sign  = (byte_i == CH_PLUS) || (byte_i == CH_MINUS);

  // acc * 10 + digit, never wider than four extra bits.
  assign acc_x10 = PW'({acc_q, 3'b000}) + PW'({acc_q, 1'b0}) + PW'(byte_i[3:0]);

  // Keys are at most three characters long, so only the first three matter.
  always_comb begin
    key_ok  = 1'b1;
    key_qty = QTY_BATT_V;
    if (key_len_q == KLW'(1) && key_chars_q[0] == CH_V) begin
      key_qty = QTY_BATT_V;
    end else if (key_len_q == KLW'(3) && key_chars_q[0] == CH_V &&
                 key_chars_q[1] == CH_P && key_chars_q[2] == CH_V) begin
      key_qty = QTY_PANEL_V;
    end else if (key_len_q == KLW'(3) && key_chars_q[0] == CH_P &&
                 key_chars_q[1] == CH_P && key_chars_q[2] == CH_V) begin
      key_qty = QTY_PANEL_P;
    end else if (key_len_q == KLW'(1) && key_chars_q[0] == CH_I) begin
      key_qty = QTY_CURRENT;
    end else if (key_len_q == KLW'(2) && key_chars_q[0] == CH_C &&
                 key_chars_q[1] == CH_S) begin
      key_qty = QTY_CHARGE_S;
    end else begin
      key_ok = 1'b0;
    end
  end

  always_comb begin
    res_o.valid = byte_en_i && is_nl && in_value_q && key_ok;
    res_o.qty   = key_qty;
    res_o.neg   = minus_q && (acc_q != '0);
  end
  assign mag_o = acc_q;

  always_comb begin
    key_chars_d = key_chars_q;
    key_len_d   = key_len_q;
    in_value_d  = in_value_q;
    started_d   = started_q;
    done_d      = done_q;
    minus_d     = minus_q;
    acc_d       = acc_q;
    if (byte_en_i) begin
      if (is_nl) begin
        for (int i = 0; i < KEY_CHARS; i++) begin
          key_chars_d[i] = '0;
        end
        key_len_d  = '0;
        in_value_d = 1'b0;
        started_d  = 1'b0;
        done_d     = 1'b0;
        minus_d    = 1'b0;
        acc_d      = '0;
      end else if (!in_value_q) begin
        if (byte_i == CH_TAB) begin
          in_value_d = 1'b1;
        end else if (key_len_q < KEY_LEN_MAX) begin
          for (int i = 0; i < KEY_CHARS; i++) begin
            if (KLW'(i) == key_len_q) begin
              key_chars_d[i] = byte_i;
            end
          end
          key_len_d = key_len_q + KLW'(1);
        end else begin
          key_len_d = KEY_LEN_LONG;
        end
      end else if (byte_i == CH_TAB) begin
        // A tab separates pairs, so it closes the first value.
        done_d = 1'b1;
      end else if (!done_q) begin
        if (is_digit) begin
          started_d = 1'b1;
          if (acc_x10[PW-1:VALUE_BITS] != '0) begin
            acc_d = '1;
          end else begin
            acc_d = acc_x10[VALUE_BITS-1:0];
          end
        end else if (!started_q && is_blank) begin
          acc_d = acc_q;
        end else if (!started_q && is_sign) begin
          started_d = 1'b1;
          minus_d   = (byte_i == CH_MINUS);
        end else begin
          done_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < KEY_CHARS; i++) begin
        key_chars_q[i] <= '0;
      end
      key_len_q  <= '0;
      in_value_q <= 1'b0;
      started_q  <= 1'b0;
      done_q     <= 1'b0;
      minus_q    <= 1'b0;
      acc_q      <= '0;
    end else begin
      key_chars_q <= key_chars_d;
      key_len_q   <= key_len_d;
      in_value_q  <= in_value_d;
      started_q   <= started_d;
      done_q      <= done_d;
      minus_q     <= minus_d;
      acc_q       <= acc_d;
    end
  end

  `TTLP_ASSERT(a_key_len_range, clk_i, rst_ni, key_len_q <= KEY_LEN_LONG, "key length out of range")
  `TTLP_ASSERT_NEXT(a_nl_clears, clk_i, rst_ni, byte_en_i && is_nl, !in_value_q && key_len_q == '0 && acc_q == '0, "newline did not clear line state")
  `TTLP_ASSERT_IMPL(a_minus_needs_start, clk_i, rst_ni, minus_q, started_q && in_value_q, "minus flag without a started value")

endmodule

/* rtl/core/ttlp_scale.sv */
// Three-stage scaling pipeline: magnitude / 1000, remainder, remainder / 10,
// ending in the output register. Depends on ttlp_pkg.
`include "text_telemetry_line_parser_assert.svh"

module ttlp_scale #(
  parameter int unsigned VALUE_BITS = ttlp_pkg::VALUE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ttlp_pkg::line_res_t           res_i,
  input  logic [VALUE_BITS-1:0]         mag_i,
  output logic                          take_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [ttlp_pkg::OUT_W-1:0]    out_data_o
);
  import ttlp_pkg::*;

  logic      v1_q, v2_q, v3_q;
  logic      en1, en2, en3;
  quot_stg_t s1_q, s1_d;
  rem_stg_t  s2_q, s2_d;
  logic [OUT_W-1:0] s3_q, s3_d;

  logic [DIV_W-1:0]     x32;
  logic [PROD_W-1:0]    prod;
  logic [TEN_MUL_W-1:0] hmul;

  // A stage moves on when it is empty or its successor moves on.
  assign en3    = !v3_q || out_ready_i;
  assign en2    = !v2_q || en3;
  assign en1    = !v1_q || en2;
  assign take_o = en1;

  always_comb begin
    x32         = DIV_W'(mag_i);
    prod        = PROD_W'(x32) * PROD_W'(RECIP_1000);
    s1_d.qty    = res_i.qty;
    s1_d.neg    = res_i.neg;
    s1_d.mag    = MAG_W'(x32);
    s1_d.whole  = prod[RECIP_SHIFT +: WHOLE_W];
    s1_d.x_low  = x32[REM_W-1:0];
  end

  // The remainder is below 1000, so arithmetic modulo 1024 is exact.
  always_comb begin
    s2_d.qty   = s1_q.qty;
    s2_d.neg   = s1_q.neg;
    s2_d.mag   = s1_q.mag;
    s2_d.whole = s1_q.whole;
    s2_d.rem   = REM_W'(s1_q.x_low - REM_W'(s1_q.whole[REM_W-1:0] * THOUSAND));
  end

  always_comb begin
    hmul = TEN_MUL_W'(s2_q.rem) * RECIP_10;
    s3_d = {hmul[TEN_SHIFT +: HUND_W], s2_q.whole, s2_q.neg, s2_q.mag, s2_q.qty};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) begin
        v1_q <= res_i.valid;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
      if (en3) begin
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      s1_q <= s1_d;
    end
    if (en2) begin
      s2_q <= s2_d;
    end
    if (en3) begin
      s3_q <= s3_d;
    end
  end

  assign out_valid_o = v3_q;
  assign out_data_o  = s3_q;

  `TTLP_ASSERT_IMPL(a_rem_range, clk_i, rst_ni, v2_q, s2_q.rem < THOUSAND, "remainder not below 1000")
  `TTLP_ASSERT_IMPL(a_hund_range, clk_i, rst_ni, v3_q, s3_q[OUT_W-1 -: HUND_W] <= HUND_W'(99), "hundredths above 99")
  `TTLP_ASSERT_NEXT(a_out_held, clk_i, rst_ni, v3_q && !out_ready_i, v3_q, "stalled result dropped")

endmodule

/* rtl/core/text_telemetry_line_parser.sv */
// Top level of the telemetry text line parser.
// Depends on ttlp_pkg, ttlp_parser and ttlp_scale.
//
//  Channel   Dir  Signals                 Contents
//  s_axis    in   tvalid/tready/tdata[8]  one received character per transfer
//  m_axis    out  tvalid/tready/tdata[56] one decoded line per transfer
//
// A byte can be accepted in every cycle while s_axis_tready is high.
// After its newline a recognized line is registered in turn after the
// divide-by-1000 multiply, after the remainder and after the divide by ten
// into the output register.
// Reset clears the line state and all pipeline valid flags at once.
// A stalled output holds its result; the stall walks back through the full
// pipeline stages, so s_axis_tready falls only when all three stages are full.
module text_telemetry_line_parser #(
  parameter int unsigned VALUE_BITS = ttlp_pkg::VALUE_BITS_DEF,
  parameter int unsigned KEY_CHARS  = ttlp_pkg::KEY_CHARS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [7:0]                       s_axis_tdata,  // [7:0] rx_byte
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [2:0] quantity, [26:3] raw_magnitude, [27] is_negative,
  // [42:28] whole_part, [49:43] hundredths, [55:50] zero
  output logic [ttlp_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import ttlp_pkg::*;

  line_res_t             line_res;
  logic [VALUE_BITS-1:0] line_mag;
  logic                  take;
  logic [OUT_W-1:0]      out_data;

  // The parser sees a byte only in the cycle of its transfer.
  ttlp_parser #(
    .VALUE_BITS(VALUE_BITS),
    .KEY_CHARS (KEY_CHARS)
  ) u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .byte_en_i(s_axis_tvalid && take),
    .byte_i   (s_axis_tdata),
    .res_o    (line_res),
    .mag_o    (line_mag)
  );

  // Scaling pipeline with its own stall control; its first stage decides
  // whether a new byte, and so a possible result, can be taken.
  ttlp_scale #(
    .VALUE_BITS(VALUE_BITS)
  ) u_scale (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .res_i      (line_res),
    .mag_i      (line_mag),
    .take_o     (take),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_data_o (out_data)
  );

  assign s_axis_tready = take;
  assign m_axis_tdata  = OUT_TDATA_W'(out_data);

endmodule
